[hw/rtl/sbl_pkg.sv]
`default_nettype none

package sbl_pkg;

	localparam int unsigned MAX_FRAME_BITS_DEF = 1024;
	localparam int unsigned SAMPLE_WIDTH_DEF   = 16;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned BITS_W     = 11;
	localparam int unsigned STEP_W     = 10;
	localparam int unsigned SMP_W      = 16;
	localparam int unsigned LLR_W      = 16;
	localparam int unsigned POS_W      = 10;
	localparam int unsigned SCR_W      = 15;
	localparam int unsigned FRAC_W     = 16;
	localparam int unsigned SCALE_W    = 32;
	localparam int unsigned SUMSQ_W    = 63;
	localparam int unsigned G_W        = 40;
	localparam int unsigned DIV_W      = 64;
	localparam int unsigned DIV_CNT_W  = $clog2(DIV_W + 1);

	localparam logic [SCR_W-1:0]   SCR_SEED       = 15'h4a80;
	localparam logic [BITS_W-1:0]  SHORT_BITS_RST = 11'd384;
	localparam logic [BITS_W-1:0]  LONG_BITS_RST  = 11'd768;
	localparam logic [STEP_W-1:0]  STEP_RST       = 10'd1;
	localparam logic [DIV_W-1:0]   EPS_Q32        = 64'd4294967;
	localparam logic [DIV_W-1:0]   SUMSQ_LIMIT    = 64'h4000_0000_0000_0000;

	localparam logic ACTION_LOAD = 1'b0;
	localparam logic ACTION_READ = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_MODE  = 3'd0,
		REG_SHORT_BITS  = 3'd1,
		REG_LONG_BITS   = 3'd2,
		REG_SHORT_STEP  = 3'd3,
		REG_LONG_STEP   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic              action;
		logic signed [SMP_W-1:0] sample;
	} req_t;

	typedef struct packed {
		logic signed [LLR_W-1:0] llr;
		logic [POS_W-1:0]  position;
		logic              last;
		logic              valid_res;
	} rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
		logic [DIV_W-1:0] remainder;
	} div_res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SUM,
		ST_SUM_END,
		ST_CHK,
		ST_E_RD,
		ST_E_MUL,
		ST_E_DIV,
		ST_E_SQ,
		ST_E_ACC,
		ST_G_DIV,
		ST_NN,
		ST_NNG,
		ST_SC_DIV,
		ST_M1_DIV,
		ST_M7_DIV,
		ST_M8_DIV,
		ST_RD1,
		ST_RD2,
		ST_NRDY
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/sbl_stream_if.sv]
`default_nettype none

interface sbl_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/soft_bit_llr_descramble_deinterleave.sv]
// Channel  Role    Payload                          Transaction
// req      sink    action, sample                   valid & ready
// rsp      source  llr, position, last, valid_res   valid & ready
// cfg      write   cfg_index, cfg_wdata             cfg_wr_en
//
// A load writes one sample to the sample memory; a read passes the sample memory read,
// scale multiply and output register, and a read before the frame is ready returns
// an all-zero result. Once the frame is full the statistics run on the bit-serial
// 64-step divider: one division per sample plus five per frame (three if all samples are zero).
// Stores come up undefined; reset clears config, state, counters, flags, scale and the scrambler.
// A result waiting on rsp holds the next read at its output register, which blocks loads too.
`default_nettype none

module soft_bit_llr_descramble_deinterleave
	import sbl_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BITS = MAX_FRAME_BITS_DEF,
	parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	sbl_stream_if.sink                 req,
	sbl_stream_if.source               rsp,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int unsigned AW   = $clog2(MAX_FRAME_BITS);
	localparam int unsigned CW   = $clog2(MAX_FRAME_BITS + 1);
	localparam int unsigned LW   = (CW > BITS_W) ? CW : BITS_W;
	localparam int unsigned EW   = (SAMPLE_WIDTH < SMP_W) ? SAMPLE_WIDTH : SMP_W;
	localparam int unsigned AWID = EW + CW;
	localparam int unsigned XW   = CW + FRAC_W;
	localparam int unsigned SQW  = 2 * XW;
	localparam int unsigned NNW  = 2 * CW;
	localparam int unsigned NNGW = NNW + G_W;
	localparam int unsigned PW   = EW + SCALE_W;
	localparam int unsigned MHW  = PW - FRAC_W;

	function automatic logic [AW-1:0] mod_add(logic [AW-1:0] a, logic [AW-1:0] b,
		logic [CW-1:0] n);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(n)) begin
			s = s - (CW+1)'(n);
		end
		return AW'(s);
	endfunction

	function automatic logic [AW-1:0] mod_sub(logic [AW-1:0] a, logic [AW-1:0] b,
		logic [CW-1:0] n);
		logic [CW:0] s;
		if (a >= b) begin
			s = (CW+1)'(a) - (CW+1)'(b);
		end else begin
			s = (CW+1)'(a) + (CW+1)'(n) - (CW+1)'(b);
		end
		return AW'(s);
	endfunction

	state_t state_q, state_d;

	logic              frame_mode_q;
	logic [BITS_W-1:0] short_bits_q, long_bits_q;
	logic [STEP_W-1:0] short_step_q, long_step_q;

	logic [SCR_W-1:0]   scr_q;
	logic [CW-1:0]      load_count_q, read_count_q, frame_len_q;
	logic [STEP_W-1:0]  frame_step_q;
	logic               frame_ready_q;
	logic [SCALE_W-1:0] scale_q;
	logic [AW-1:0]      idx_q, m_q, base_q, s1_q, s7_q, s8_q;
	logic [AWID-1:0]    a_q, d_q;
	logic [XW-1:0]      x_q;
	logic [SQW-1:0]     sq_q;
	logic [SUMSQ_W-1:0] sumsq_q;
	logic [G_W-1:0]     g_q;
	logic [NNW-1:0]     nn_q;
	logic [NNGW-1:0]    nng_q;
	logic               div_go_q;
	logic               rdv_s1;
	logic [PW-1:0]      prod_s1;
	logic               neg_s1;
	rsp_t               rsp_q;
	logic               rsp_v_q;

	logic [LW-1:0]           len_sel, len_clamp;
	logic [CW-1:0]           cur_len;
	logic                    req_fire, is_load, load_ok, load_wr, go_compute;
	logic [CW-1:0]           lc_next;
	logic                    scr_bit;
	logic signed [EW-1:0]    smp_in;
	logic [SAMPLE_WIDTH-1:0] smp_wdata;
	logic [AW-1:0]           smp_raddr;
	logic [SAMPLE_WIDTH-1:0] smp_rdata;
	logic [0:0]              sgn_rdata;
	logic [EW-1:0]           rd_raw, rd_mag;
	logic                    idx_last;
	logic                    out_free;
	logic                    byte_end;
	logic [DIV_W-1:0]        sum64;
	logic [MHW-1:0]          mag_hi;
	logic [LLR_W-1:0]        llr_val;
	div_req_t                div_req;
	div_res_t                div_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= 1'b0;
			short_bits_q <= SHORT_BITS_RST;
			long_bits_q  <= LONG_BITS_RST;
			short_step_q <= STEP_RST;
			long_step_q  <= STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_MODE: frame_mode_q <= cfg_wdata[0];
				REG_SHORT_BITS: short_bits_q <= cfg_wdata[BITS_W-1:0];
				REG_LONG_BITS:  long_bits_q  <= cfg_wdata[BITS_W-1:0];
				REG_SHORT_STEP: short_step_q <= cfg_wdata[STEP_W-1:0];
				REG_LONG_STEP:  long_step_q  <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len_sel   = LW'(frame_mode_q ? long_bits_q : short_bits_q);
		len_clamp = (len_sel > LW'(MAX_FRAME_BITS)) ? LW'(MAX_FRAME_BITS) : len_sel;
		len_clamp = len_clamp & ~LW'(7);
		if (len_clamp < LW'(8)) begin
			len_clamp = LW'(8);
		end
		cur_len = CW'(len_clamp);
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign is_load    = (req.data.action == ACTION_LOAD);
	assign load_ok    = req_fire && is_load && !frame_ready_q;
	assign load_wr    = load_ok && (load_count_q < cur_len);
	assign lc_next    = load_wr ? load_count_q + 1'b1 : load_count_q;
	assign go_compute = load_ok && (lc_next >= cur_len);
	assign scr_bit    = scr_q[0] ^ scr_q[1];
	assign smp_in     = req.data.sample[EW-1:0];
	assign smp_wdata  = SAMPLE_WIDTH'(smp_in);
	assign smp_raddr  = (state_q == ST_IDLE) ? (m_q ^ AW'(7)) : idx_q;
	assign rd_raw     = smp_rdata[EW-1:0];
	assign rd_mag     = rd_raw[EW-1] ? (~rd_raw + 1'b1) : rd_raw;
	assign idx_last   = (CW'(idx_q) == frame_len_q - 1'b1);
	assign out_free   = !rsp_v_q || rsp.ready;
	assign byte_end   = (read_count_q[2:0] == 3'd7);
	assign sum64      = DIV_W'(sumsq_q) + DIV_W'(sq_q);
	assign mag_hi     = prod_s1[PW-1:FRAC_W];

	always_comb begin
		if (neg_s1) begin
			llr_val = (mag_hi >= MHW'(32768)) ? 16'h8000 : (~mag_hi[LLR_W-1:0] + 1'b1);
		end else begin
			llr_val = (mag_hi > MHW'(32767)) ? 16'h7fff : mag_hi[LLR_W-1:0];
		end
	end

	sbl_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_FRAME_BITS)) u_smp_ram (
		.clk   (clk),
		.we    (load_wr),
		.waddr (load_count_q[AW-1:0]),
		.wdata (smp_wdata),
		.raddr (smp_raddr),
		.rdata (smp_rdata)
	);

	sbl_ram #(.WIDTH(1), .DEPTH(MAX_FRAME_BITS)) u_sgn_ram (
		.clk   (clk),
		.we    (load_wr),
		.waddr (load_count_q[AW-1:0]),
		.wdata (scr_bit),
		.raddr (m_q),
		.rdata (sgn_rdata)
	);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = DIV_W'(1);
		case (state_q)
			ST_E_DIV: begin
				div_req.start    = !div_go_q;
				div_req.dividend = DIV_W'({d_q, {FRAC_W{1'b0}}});
				div_req.divisor  = DIV_W'(a_q);
			end
			ST_G_DIV: begin
				div_req.start    = !div_go_q;
				div_req.dividend = SUMSQ_LIMIT;
				div_req.divisor  = DIV_W'(sumsq_q) + EPS_Q32;
			end
			ST_SC_DIV: begin
				div_req.start    = !div_go_q;
				div_req.dividend = DIV_W'(nng_q);
				div_req.divisor  = DIV_W'({a_q, 5'b00000});
			end
			ST_M1_DIV: begin
				div_req.start    = !div_go_q;
				div_req.dividend = DIV_W'(frame_step_q);
				div_req.divisor  = DIV_W'(frame_len_q);
			end
			ST_M7_DIV: begin
				div_req.start    = !div_go_q;
				div_req.dividend = DIV_W'({frame_step_q, 3'b000}) - DIV_W'(frame_step_q);
				div_req.divisor  = DIV_W'(frame_len_q);
			end
			ST_M8_DIV: begin
				div_req.start    = !div_go_q;
				div_req.dividend = DIV_W'({frame_step_q, 3'b000});
				div_req.divisor  = DIV_W'(frame_len_q);
			end
			default: ;
		endcase
	end

	sbl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (!is_load) begin
						state_d = frame_ready_q ? ST_RD1 : ST_NRDY;
					end else if (go_compute) begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM:     if (idx_last) state_d = ST_SUM_END;
			ST_SUM_END: state_d = ST_CHK;
			ST_CHK:     state_d = (a_q == '0) ? ST_M1_DIV : ST_E_RD;
			ST_E_RD:    state_d = ST_E_MUL;
			ST_E_MUL:   state_d = ST_E_DIV;
			ST_E_DIV:   if (div_res.done) state_d = ST_E_SQ;
			ST_E_SQ:    state_d = ST_E_ACC;
			ST_E_ACC:   state_d = idx_last ? ST_G_DIV : ST_E_RD;
			ST_G_DIV:   if (div_res.done) state_d = ST_NN;
			ST_NN:      state_d = ST_NNG;
			ST_NNG:     state_d = ST_SC_DIV;
			ST_SC_DIV:  if (div_res.done) state_d = ST_M1_DIV;
			ST_M1_DIV:  if (div_res.done) state_d = ST_M7_DIV;
			ST_M7_DIV:  if (div_res.done) state_d = ST_M8_DIV;
			ST_M8_DIV:  if (div_res.done) state_d = ST_IDLE;
			ST_RD1:     state_d = ST_RD2;
			ST_RD2:     if (out_free) state_d = ST_IDLE;
			ST_NRDY:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_q         <= SCR_SEED;
			load_count_q  <= '0;
			read_count_q  <= '0;
			frame_ready_q <= 1'b0;
			scale_q       <= '0;
			frame_len_q   <= '0;
			frame_step_q  <= '0;
			div_go_q      <= 1'b0;
			rdv_s1        <= 1'b0;
			rsp_v_q       <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_SUM);
			if (div_req.start) begin
				div_go_q <= 1'b1;
			end else if (div_res.done) begin
				div_go_q <= 1'b0;
			end
			if (load_wr) begin
				scr_q        <= {scr_bit, scr_q[SCR_W-1:1]};
				load_count_q <= lc_next;
			end
			if (go_compute) begin
				scr_q        <= SCR_SEED;
				frame_len_q  <= cur_len;
				frame_step_q <= frame_mode_q ? long_step_q : short_step_q;
			end
			if (state_q == ST_CHK && a_q == '0) begin
				scale_q <= '0;
			end
			if (state_q == ST_SC_DIV && div_res.done) begin
				scale_q <= (|div_res.quotient[DIV_W-1:SCALE_W]) ? '1
					: div_res.quotient[SCALE_W-1:0];
			end
			if (state_q == ST_M8_DIV && div_res.done) begin
				read_count_q  <= '0;
				frame_ready_q <= 1'b1;
			end
			if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			if ((state_q == ST_RD2 || state_q == ST_NRDY) && out_free) begin
				rsp_v_q <= 1'b1;
			end
			if (state_q == ST_RD2 && out_free) begin
				if ((CW+1)'(read_count_q) + 1'b1 >= (CW+1)'(frame_len_q)) begin
					frame_ready_q <= 1'b0;
					load_count_q  <= '0;
					read_count_q  <= '0;
				end else begin
					read_count_q <= read_count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (go_compute) begin
					idx_q <= '0;
					a_q   <= '0;
				end
			end
			ST_SUM: idx_q <= idx_q + 1'b1;
			ST_CHK: begin
				idx_q   <= '0;
				sumsq_q <= '0;
			end
			ST_E_MUL: begin
				d_q <= (AWID'(rd_mag) * AWID'(frame_len_q) > a_q)
					? AWID'(rd_mag) * AWID'(frame_len_q) - a_q
					: a_q - AWID'(rd_mag) * AWID'(frame_len_q);
			end
			ST_E_DIV: if (div_res.done) x_q <= div_res.quotient[XW-1:0];
			ST_E_SQ:  sq_q <= SQW'(x_q) * SQW'(x_q);
			ST_E_ACC: begin
				sumsq_q <= (sum64 > SUMSQ_LIMIT) ? SUMSQ_LIMIT[SUMSQ_W-1:0]
					: sum64[SUMSQ_W-1:0];
				idx_q   <= idx_q + 1'b1;
			end
			ST_G_DIV: if (div_res.done) g_q <= div_res.quotient[G_W-1:0];
			ST_NN:    nn_q <= NNW'(frame_len_q) * NNW'(frame_len_q);
			ST_NNG:   nng_q <= NNGW'(nn_q) * NNGW'(g_q);
			ST_M1_DIV: if (div_res.done) s1_q <= div_res.remainder[AW-1:0];
			ST_M7_DIV: if (div_res.done) s7_q <= div_res.remainder[AW-1:0];
			ST_M8_DIV: begin
				if (div_res.done) begin
					s8_q   <= div_res.remainder[AW-1:0];
					m_q    <= s7_q;
					base_q <= '0;
				end
			end
			ST_RD1: begin
				prod_s1 <= PW'(rd_mag) * PW'(scale_q);
				neg_s1  <= rd_raw[EW-1] ^ ~sgn_rdata[0];
				if (byte_end) begin
					base_q <= mod_add(base_q, s8_q, frame_len_q);
				end
			end
			ST_RD2: begin
				if (out_free) begin
					rsp_q.llr       <= llr_val;
					rsp_q.position  <= POS_W'(read_count_q);
					rsp_q.last      <= ((CW+1)'(read_count_q) + 1'b1 == (CW+1)'(frame_len_q));
					rsp_q.valid_res <= 1'b1;
					m_q <= byte_end ? mod_add(base_q, s7_q, frame_len_q)
						: mod_sub(m_q, s1_q, frame_len_q);
				end
			end
			ST_NRDY: if (out_free) rsp_q <= '0;
			default: ;
		endcase
		if (rdv_s1) begin
			a_q <= a_q + AWID'(rd_mag);
		end
	end

	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	a_frame_counts: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ready_q |-> (load_count_q >= frame_len_q) && (read_count_q < frame_len_q)
			&& (CW'(m_q) < frame_len_q))
		else $error("frame counters out of range while frame is ready");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> div_go_q)
		else $error("divider finished without a pending request");

	a_ready_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frame_ready_q) |-> $past(state_q) == ST_M8_DIV)
		else $error("frame marked ready outside the final division");
endmodule

`default_nettype wire

[hw/rtl/sbl_ram.sv]
`default_nettype none

module sbl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

[hw/rtl/sbl_divider.sv]
`default_nettype none

module sbl_divider
	import sbl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_res_t      res
);
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       trial;
	logic                 ge;
	logic [DIV_W:0]       diff;

	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign res = {done_q, quo_q, rem_q};
endmodule

`default_nettype wire

[sim/sbl_checker.sv]
`default_nettype none

module sbl_checker
	import sbl_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire logic                  req_ready,
	input  wire req_t                  req_data,
	input  wire logic                  rsp_valid,
	input  wire logic                  rsp_ready,
	input  wire rsp_t                  rsp_data,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                         pending,
	output int                         errors
);
	timeunit 1ns;
	timeprecision 1ps;

	logic                    mode;
	logic [BITS_W-1:0]       bits_short, bits_long;
	logic [STEP_W-1:0]       step_short, step_long;
	logic signed [SMP_W-1:0] soft_mem [MAX_FRAME_BITS_DEF];
	logic                    flip_mem [MAX_FRAME_BITS_DEF];
	logic [SCR_W-1:0]        lfsr;
	int unsigned             n_loaded, n_read, len_lat, step_lat;
	logic [SCALE_W-1:0]      gain;
	logic                    computed;
	rsp_t                    llr_q [$];

	function automatic int unsigned sel_len();
		int unsigned v;
		v = mode ? bits_long : bits_short;
		if (v > MAX_FRAME_BITS_DEF) v = MAX_FRAME_BITS_DEF;
		v = v & ~32'd7;
		if (v < 8) v = 8;
		return v;
	endfunction

	function automatic longint unsigned magnitude(logic signed [SMP_W-1:0] s);
		longint signed w;
		w = s;
		return (w < 0) ? longint'(-w) : longint'(w);
	endfunction

	function automatic int unsigned swap_bits(int unsigned x);
		return (x & ~32'd7) | (7 - (x & 7));
	endfunction

	task automatic derive_gain(int unsigned n);
		longint unsigned a, sumsq, t, d, x, sq, g, sc;
		a = 0;
		sumsq = 0;
		for (int unsigned i = 0; i < n; i++) a += magnitude(soft_mem[i]);
		if (a == 0) begin
			gain = '0;
		end else begin
			for (int unsigned i = 0; i < n; i++) begin
				t = magnitude(soft_mem[i]) * n;
				d = (t > a) ? t - a : a - t;
				x = (d << 16) / a;
				sq = x * x;
				if (sumsq > SUMSQ_LIMIT - sq || sq > SUMSQ_LIMIT) sumsq = SUMSQ_LIMIT;
				else sumsq += sq;
			end
			g = SUMSQ_LIMIT / (sumsq + EPS_Q32);
			sc = (longint'(n) * n * g) / (32 * a);
			gain = (sc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sc[31:0];
		end
		len_lat = n;
		step_lat = mode ? step_long : step_short;
		lfsr = SCR_SEED;
		n_read = 0;
		computed = 1'b1;
	endtask

	task automatic take_item(req_t it);
		int unsigned n, m, j;
		logic fb;
		longint unsigned mag;
		logic neg;
		rsp_t r;
		if (it.action == ACTION_LOAD) begin
			if (computed) return;
			n = sel_len();
			if (n_loaded < n) begin
				soft_mem[n_loaded] = it.sample;
				fb = lfsr[0] ^ lfsr[1];
				flip_mem[n_loaded] = fb;
				lfsr = {fb, lfsr[SCR_W-1:1]};
				n_loaded++;
			end
			if (n_loaded >= n) derive_gain(n);
			return;
		end
		r = '0;
		if (computed && len_lat != 0) begin
			m = (longint'(step_lat) * swap_bits(n_read)) % len_lat;
			j = swap_bits(m);
			mag = (magnitude(soft_mem[j]) * gain) >> 16;
			neg = (soft_mem[j] < 0) != (flip_mem[m] == 1'b0);
			if (neg) begin
				if (mag > 32768) mag = 32768;
				r.llr = 16'((65536 - mag) & 16'hFFFF);
			end else begin
				if (mag > 32767) mag = 32767;
				r.llr = 16'(mag);
			end
			r.position = n_read[POS_W-1:0];
			r.last = (n_read + 1 == len_lat);
			r.valid_res = 1'b1;
			n_read++;
			if (n_read >= len_lat) begin
				computed = 1'b0;
				n_loaded = 0;
				n_read = 0;
			end
		end
		llr_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			mode = 1'b0;
			bits_short = SHORT_BITS_RST;
			bits_long = LONG_BITS_RST;
			step_short = STEP_RST;
			step_long = STEP_RST;
			lfsr = SCR_SEED;
			n_loaded = 0;
			n_read = 0;
			gain = '0;
			computed = 1'b0;
			len_lat = 0;
			step_lat = 0;
			llr_q.delete();
			pending <= 0;
			errors <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_FRAME_MODE: mode = cfg_wdata[0];
					REG_SHORT_BITS: bits_short = cfg_wdata[BITS_W-1:0];
					REG_LONG_BITS:  bits_long = cfg_wdata[BITS_W-1:0];
					REG_SHORT_STEP: step_short = cfg_wdata[STEP_W-1:0];
					REG_LONG_STEP:  step_long = cfg_wdata[STEP_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (llr_q.size() == 0) begin
					$display("%0t: unexpected transaction llr=%0d pos=%0d last=%0b vr=%0b",
						$time, rsp_data.llr, rsp_data.position, rsp_data.last,
						rsp_data.valid_res);
					errors <= errors + 1;
				end else begin
					e = llr_q.pop_front();
					if (e !== rsp_data) begin
						$display("%0t: mismatch expected llr=%0d pos=%0d last=%0b vr=%0b, %s",
							$time, e.llr, e.position, e.last, e.valid_res, "got");
						$display("%0t:   actual llr=%0d pos=%0d last=%0b vr=%0b",
							$time, rsp_data.llr, rsp_data.position, rsp_data.last,
							rsp_data.valid_res);
						errors <= errors + 1;
					end
				end
			end
			if (req_valid && req_ready) take_item(req_data);
			pending <= llr_q.size();
		end
	end
endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top
	import sbl_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 3000000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    pending, errors;
	int unsigned           cycles, n_items, tx_idle, rx_idle;
	logic                  cur_mode;
	int unsigned           cur_short, cur_long;

	sbl_stream_if #(.payload_t(req_t)) req_if ();
	sbl_stream_if #(.payload_t(rsp_t)) rsp_if ();

	soft_bit_llr_descramble_deinterleave u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	sbl_checker u_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_if.valid),
		.req_ready(req_if.ready),
		.req_data (req_if.data),
		.rsp_valid(rsp_if.valid),
		.rsp_ready(rsp_if.ready),
		.rsp_data (rsp_if.data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pending  (pending),
		.errors   (errors)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		rsp_if.ready <= ($urandom_range(99) >= rx_idle);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic int unsigned frame_bits();
		int unsigned v;
		v = cur_mode ? cur_long : cur_short;
		if (v > MAX_FRAME_BITS_DEF) v = MAX_FRAME_BITS_DEF;
		v = v & ~32'd7;
		return (v < 8) ? 8 : v;
	endfunction

	function automatic logic [SMP_W-1:0] soft_value();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'(int'($urandom_range(512)) - 256);
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send(logic act, logic [SMP_W-1:0] smp);
		req_t it;
		if (n_items == 433) begin
			tx_idle = 88;
			rx_idle = 26;
		end else if (n_items == 866) begin
			tx_idle = 0;
			rx_idle = 0;
		end
		if ($urandom_range(99) < tx_idle) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		it.action = act;
		it.sample = smp;
		req_if.valid <= 1'b1;
		req_if.data <= it;
		do @(posedge clk); while (!req_if.ready);
		n_items++;
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic reg_write(cfg_reg_t idx, int unsigned val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_FRAME_MODE: cur_mode = val[0];
			REG_SHORT_BITS: cur_short = val & 32'h7FF;
			REG_LONG_BITS:  cur_long = val & 32'h7FF;
			default: ;
		endcase
	endtask

	task automatic load_n(int unsigned k, bit noisy);
		for (int unsigned i = 0; i < k; i++) begin
			if (noisy && $urandom_range(19) == 0) send(ACTION_READ, 16'($urandom));
			send(ACTION_LOAD, soft_value());
		end
	endtask

	task automatic read_n(int unsigned k, bit retune);
		for (int unsigned i = 0; i < k; i++) begin
			send(ACTION_READ, 16'($urandom));
			if (retune && i == 0) begin
				reg_write(cur_mode ? REG_LONG_STEP : REG_SHORT_STEP,
					$urandom_range(1023));
			end
		end
	endtask

	initial begin
		int unsigned n;
		cycles = 0;
		n_items = 0;
		tx_idle = 26;
		rx_idle = 88;
		cur_mode = 1'b0;
		cur_short = 384;
		cur_long = 768;
		arst_n = 1'b0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ACTION_READ, 16'h0000);
		reg_write(REG_SHORT_BITS, 8);
		reg_write(REG_SHORT_STEP, 3);
		send(ACTION_LOAD, 16'h8000);
		send(ACTION_LOAD, 16'h7FFF);
		send(ACTION_LOAD, 16'h0000);
		send(ACTION_LOAD, 16'h0001);
		send(ACTION_LOAD, 16'hFFFF);
		send(ACTION_LOAD, 16'h5555);
		send(ACTION_LOAD, 16'hAAAA);
		send(ACTION_LOAD, 16'h0100);
		send(ACTION_LOAD, 16'h1234);
		read_n(8, 1'b1);
		for (int i = 0; i < 8; i++) send(ACTION_LOAD, 16'h0000);
		read_n(8, 1'b0);
		reg_write(REG_SHORT_BITS, 16);
		reg_write(REG_SHORT_STEP, 4);
		load_n(12, 1'b0);
		reg_write(REG_SHORT_BITS, 8);
		send(ACTION_LOAD, 16'h4000);
		read_n(8, 1'b0);
		reg_write(REG_FRAME_MODE, 1);
		reg_write(REG_LONG_STEP, 1023);
		reg_write(REG_LONG_BITS, 2047);
		load_n(8, 1'b0);
		reg_write(REG_LONG_BITS, 1024);
		load_n(8, 1'b0);
		reg_write(REG_LONG_BITS, 13);
		send(ACTION_LOAD, 16'h0200);
		read_n(8, 1'b0);
		reg_write(REG_LONG_STEP, 0);
		load_n(8, 1'b0);
		read_n(8, 1'b0);
		reg_write(REG_FRAME_MODE, 0);
		reg_write(REG_SHORT_BITS, 1023);
		reg_write(REG_SHORT_BITS, 24);
		reg_write(REG_SHORT_STEP, 5);
		load_n(24, 1'b0);
		read_n(24, 1'b0);

		while (n_items < 1300) begin
			if ($urandom_range(3) == 0) reg_write(REG_FRAME_MODE, $urandom_range(1));
			if ($urandom_range(2) == 0) begin
				reg_write(REG_SHORT_BITS, ($urandom_range(9) == 0) ?
					$urandom_range(2047) % 80 : 8 * $urandom_range(1, 8));
				reg_write(REG_LONG_BITS, 8 * $urandom_range(1, 8) + $urandom_range(7));
			end
			if ($urandom_range(2) == 0) begin
				reg_write(REG_SHORT_STEP, ($urandom_range(7) == 0) ? 1023 : $urandom_range(1, 1023));
				reg_write(REG_LONG_STEP, $urandom_range(1023));
			end
			n = frame_bits();
			load_n(n, 1'b1);
			if ($urandom_range(4) == 0) send(ACTION_LOAD, soft_value());
			if ($urandom_range(5) == 0) drain();
			read_n(n, $urandom_range(6) == 0);
		end

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule

`default_nettype wire
